/* rtl/weight_triggered_actuator_sequencer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the weight-triggered actuator sequencer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEIGHT_TRIGGERED_ACTUATOR_SEQUENCER_UNIT_ASSERT_SVH
`define WEIGHT_TRIGGERED_ACTUATOR_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WTAS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WTAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define WTAS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define WTAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/wtas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtas_pkg
// Types and constants shared by the actuator sequencer.
// ----------------------------------------------------------------------------
package wtas_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CSR_IDX_WIDTH  = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_WEIGHT_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_WEIGHT_HYSTERESIS  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PUSH_HOLD_TICKS    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SWING_PERIOD_TICKS = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MOTOR_STOP_TICKS   = 3'd4;

   localparam logic [14:0] WEIGHT_THRESHOLD_RST   = 15'd100;
   localparam logic [14:0] WEIGHT_HYSTERESIS_RST  = 15'd10;
   localparam logic [15:0] PUSH_HOLD_TICKS_RST    = 16'd10;
   localparam logic [15:0] SWING_PERIOD_TICKS_RST = 16'd20;
   localparam logic [15:0] MOTOR_STOP_TICKS_RST   = 16'd100;

   // push arm sequence, one-hot
   typedef enum logic [3:0] {
      PUSH_IDLE  = 4'b0001,
      PUSH_START = 4'b0010,
      PUSH_HOLD  = 4'b0100,
      PUSH_PULL  = 4'b1000
   } push_phase_type;

   // saturating tick counter increment
   function automatic logic [15:0] sat_inc(input logic [15:0] value);
      logic [15:0] result;
      result = (value == 16'hFFFF) ? 16'hFFFF : value + 16'd1;
      return result;
   endfunction

endpackage

/* rtl/weight_triggered_actuator_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_triggered_actuator_sequencer_unit
// Per-tick controller for a push arm, a swing actuator and a motor relay.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one control tick: a signed gram weight sample and the raw
//    stop detector level. rsp_* returns one result per tick: arm, swing and
//    motor levels plus one-tick weight and stop event pulses.
//  - csr_* is an APB-style port, registers at byte offsets 0,4,8,12,16:
//    threshold, hysteresis, push hold, swing period, motor stop length.
//    pready is tied high. Write registers only while no request is in flight.
//  - A request is captured in an input register; from there it runs
//    through the compare/count logic and lands in the result register once
//    that register is free, and the controller state updates at that same
//    edge. rsp_valid rises when the result register is loaded.
//  - Throughput is one request per cycle; the input and result registers
//    form a two-deep pipeline, so a new request is taken while a result
//    waits. If rsp_ready stays low both stages fill and req_ready drops.
//  - Reset (synchronous, active high) holds req_ready low, clears the pipeline,
//    loads register defaults and returns the controller to idle, motor running.
// ----------------------------------------------------------------------------
`include "weight_triggered_actuator_sequencer_unit_assert.svh"

module weight_triggered_actuator_sequencer_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [15:0]                     req_weight_grams,
   input  logic                                   req_stop_signal,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_arm_pushed,
   output logic                                   rsp_swing_high,
   output logic                                   rsp_motor_run,
   output logic                                   rsp_weight_event,
   output logic                                   rsp_stop_event,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [wtas_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [wtas_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [wtas_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [14:0] weight_threshold_ff;
   logic [14:0] weight_hysteresis_ff;
   logic [15:0] push_hold_ticks_ff;
   logic [15:0] swing_period_ticks_ff;
   logic [15:0] motor_stop_ticks_ff;

   logic                               csr_wr_en;
   logic [wtas_pkg::CSR_IDX_WIDTH-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr_en  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // word addressing; byte lane bits ignored
   assign csr_idx    = csr_paddr[wtas_pkg::CSR_ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_threshold_ff   <= wtas_pkg::WEIGHT_THRESHOLD_RST;
         weight_hysteresis_ff  <= wtas_pkg::WEIGHT_HYSTERESIS_RST;
         push_hold_ticks_ff    <= wtas_pkg::PUSH_HOLD_TICKS_RST;
         swing_period_ticks_ff <= wtas_pkg::SWING_PERIOD_TICKS_RST;
         motor_stop_ticks_ff   <= wtas_pkg::MOTOR_STOP_TICKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_idx)
            wtas_pkg::REG_WEIGHT_THRESHOLD:   weight_threshold_ff   <= csr_pwdata[14:0];
            wtas_pkg::REG_WEIGHT_HYSTERESIS:  weight_hysteresis_ff  <= csr_pwdata[14:0];
            wtas_pkg::REG_PUSH_HOLD_TICKS:    push_hold_ticks_ff    <= csr_pwdata[15:0];
            wtas_pkg::REG_SWING_PERIOD_TICKS: swing_period_ticks_ff <= csr_pwdata[15:0];
            wtas_pkg::REG_MOTOR_STOP_TICKS:   motor_stop_ticks_ff   <= csr_pwdata[15:0];
            default: ; // unmapped offsets drop the write
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wtas_pkg::REG_WEIGHT_THRESHOLD:   csr_prdata = {17'd0, weight_threshold_ff};
         wtas_pkg::REG_WEIGHT_HYSTERESIS:  csr_prdata = {17'd0, weight_hysteresis_ff};
         wtas_pkg::REG_PUSH_HOLD_TICKS:    csr_prdata = {16'd0, push_hold_ticks_ff};
         wtas_pkg::REG_SWING_PERIOD_TICKS: csr_prdata = {16'd0, swing_period_ticks_ff};
         wtas_pkg::REG_MOTOR_STOP_TICKS:   csr_prdata = {16'd0, motor_stop_ticks_ff};
         default:                          csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline handshake: input register -> result register
   // ------------------------------------------------------------------
   logic               in_valid_ff;
   logic signed [15:0] in_weight_ff;
   logic               in_stop_ff;
   logic               rsp_valid_ff;
   logic               out_free;
   logic               step_en;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign step_en   = in_valid_ff & out_free;
   assign req_ready = ~reset & (~in_valid_ff | step_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_weight_ff <= req_weight_grams;
         in_stop_ff   <= req_stop_signal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Controller state
   // ------------------------------------------------------------------
   logic                     trigger_latched_ff,  trigger_latched_in;
   wtas_pkg::push_phase_type push_phase_ff,       push_phase_in;
   logic [15:0]              push_count_ff,       push_count_in;
   logic                     arm_level_ff,        arm_level_in;
   logic                     swing_enabled_ff,    swing_enabled_in;
   logic                     swing_level_ff,      swing_level_in;
   logic [15:0]              swing_count_ff,      swing_count_in;
   logic                     motor_halted_ff,     motor_halted_in;
   logic                     awaiting_release_ff, awaiting_release_in;
   logic [15:0]              halt_count_ff,       halt_count_in;
   logic                     previous_signal_ff;
   logic                     weight_event_in;
   logic                     stop_event_in;

   // weight stage signals
   logic signed [16:0]       weight_ext;
   logic signed [16:0]       thr_ext;
   logic signed [16:0]       rearm_level;
   logic                     fire;
   wtas_pkg::push_phase_type phase_mid;

   // signal stage signals
   logic                     halted_mid;
   logic [15:0]              halt_cnt_inc;

   // push / swing scratch
   logic [15:0]              push_cnt_inc;
   logic [15:0]              swing_cnt_inc;

   always_comb begin
      // weight: hysteresis trigger, compared as 17-bit signed values
      weight_ext  = {in_weight_ff[15], in_weight_ff};
      thr_ext     = $signed({2'b00, weight_threshold_ff});
      rearm_level = thr_ext - $signed({2'b00, weight_hysteresis_ff});
      fire        = (weight_ext >= thr_ext) & ~trigger_latched_ff;

      trigger_latched_in = (trigger_latched_ff | fire) & ~(weight_ext < rearm_level);
      swing_enabled_in   = swing_enabled_ff | fire;
      phase_mid          = fire ? wtas_pkg::PUSH_START : push_phase_ff;
      weight_event_in    = fire;

      // signal: debounce on two highs, timed halt, then wait for release
      awaiting_release_in = awaiting_release_ff;
      motor_halted_in     = motor_halted_ff;
      halt_count_in       = halt_count_ff;
      stop_event_in       = 1'b0;
      halted_mid          = 1'b0;
      halt_cnt_inc        = '0;
      if (awaiting_release_ff) begin
         if (!in_stop_ff) begin
            awaiting_release_in = 1'b0;
         end
      end else begin
         stop_event_in = in_stop_ff & previous_signal_ff & ~motor_halted_ff;
         halted_mid    = motor_halted_ff | stop_event_in;
         halt_cnt_inc  = wtas_pkg::sat_inc(stop_event_in ? 16'd0 : halt_count_ff);
         if (halted_mid) begin
            halt_count_in = halt_cnt_inc;
            if (halt_cnt_inc >= motor_stop_ticks_ff) begin
               motor_halted_in     = 1'b0;
               awaiting_release_in = in_stop_ff;
            end else begin
               motor_halted_in = 1'b1;
            end
         end
      end

      // push arm sequence
      push_phase_in = phase_mid;
      push_count_in = push_count_ff;
      arm_level_in  = arm_level_ff;
      push_cnt_inc  = wtas_pkg::sat_inc(push_count_ff);
      unique case (phase_mid)
         wtas_pkg::PUSH_IDLE: ;
         wtas_pkg::PUSH_START: begin
            arm_level_in  = 1'b1;
            push_phase_in = wtas_pkg::PUSH_HOLD;
            push_count_in = '0;
         end
         wtas_pkg::PUSH_HOLD: begin
            push_count_in = push_cnt_inc;
            if (push_cnt_inc >= push_hold_ticks_ff) begin
               push_phase_in = wtas_pkg::PUSH_PULL;
            end
         end
         wtas_pkg::PUSH_PULL: begin
            arm_level_in  = 1'b0;
            push_phase_in = wtas_pkg::PUSH_IDLE;
         end
         default: push_phase_in = wtas_pkg::PUSH_IDLE;
      endcase

      // swing square wave
      swing_count_in = swing_count_ff;
      swing_level_in = swing_level_ff;
      swing_cnt_inc  = wtas_pkg::sat_inc(swing_count_ff);
      if (swing_enabled_in) begin
         if (swing_cnt_inc >= swing_period_ticks_ff) begin
            swing_count_in = '0;
            swing_level_in = ~swing_level_ff;
         end else begin
            swing_count_in = swing_cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_latched_ff  <= 1'b0;
         push_phase_ff       <= wtas_pkg::PUSH_IDLE;
         push_count_ff       <= '0;
         arm_level_ff        <= 1'b0;
         swing_enabled_ff    <= 1'b0;
         swing_level_ff      <= 1'b0;
         swing_count_ff      <= '0;
         motor_halted_ff     <= 1'b0;
         awaiting_release_ff <= 1'b0;
         halt_count_ff       <= '0;
         previous_signal_ff  <= 1'b0;
      end else if (step_en) begin
         trigger_latched_ff  <= trigger_latched_in;
         push_phase_ff       <= push_phase_in;
         push_count_ff       <= push_count_in;
         arm_level_ff        <= arm_level_in;
         swing_enabled_ff    <= swing_enabled_in;
         swing_level_ff      <= swing_level_in;
         swing_count_ff      <= swing_count_in;
         motor_halted_ff     <= motor_halted_in;
         awaiting_release_ff <= awaiting_release_in;
         halt_count_ff       <= halt_count_in;
         previous_signal_ff  <= in_stop_ff;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic arm_pushed_ff, swing_high_ff, motor_run_ff, weight_event_ff, stop_event_ff;

   always_ff @(posedge clock) begin
      if (step_en) begin
         arm_pushed_ff   <= arm_level_in;
         swing_high_ff   <= swing_level_in;
         motor_run_ff    <= ~motor_halted_in;
         weight_event_ff <= weight_event_in;
         stop_event_ff   <= stop_event_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_arm_pushed   = arm_pushed_ff;
   assign rsp_swing_high   = swing_high_ff;
   assign rsp_motor_run    = motor_run_ff;
   assign rsp_weight_event = weight_event_ff;
   assign rsp_stop_event   = stop_event_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // a trigger always starts the push, so the arm is out with the event
   `WTAS_ASSERT_SAME(a_event_arm, clock, reset, rsp_valid_ff && weight_event_ff, arm_pushed_ff, "weight event without arm pushed")
   // release wait only follows a finished halt
   `WTAS_ASSERT_SAME(a_release_run, clock, reset, awaiting_release_ff, !motor_halted_ff, "awaiting release while motor halted")
   // arm is pulled whenever the sequence is idle
   `WTAS_ASSERT_SAME(a_idle_pulled, clock, reset, push_phase_ff == wtas_pkg::PUSH_IDLE, !arm_level_ff, "arm pushed in idle phase")
   // swing enable is sticky
   `WTAS_ASSERT_NEXT(a_swing_sticky, clock, reset, swing_enabled_ff, swing_enabled_ff, "swing enable dropped")

endmodule

/* bench/weight_triggered_actuator_sequencer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_triggered_actuator_sequencer_unit_tb
// Self-checking bench for the per-tick push arm, swing and motor sequencer.
// A driver streams weight/stop requests from a queue with random gaps. The
// result side stalls at random. Every accepted request runs through a local
// model of the sequencer, and each response is checked field by field
// against the oldest prediction. Registers are reprogrammed between phases,
// only while the unit is drained. The phases cover the low, high and zero
// register extremes plus random settings.
// ----------------------------------------------------------------------------
module weight_triggered_actuator_sequencer_unit_tb;

   // one control tick going in, and the levels/pulses it produces
   typedef struct {
      logic signed [15:0] weight;
      logic               stop;
   } tick_in_type;

   typedef struct packed {
      logic arm_pushed;
      logic swing_high;
      logic motor_run;
      logic weight_event;
      logic stop_event;
   } tick_out_type;

   // ------------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ------------------------------------------------------------------------
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [15:0]                  req_weight_grams = '0;
   logic                                req_stop_signal = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_arm_pushed;
   logic                                rsp_swing_high;
   logic                                rsp_motor_run;
   logic                                rsp_weight_event;
   logic                                rsp_stop_event;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [wtas_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [wtas_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [wtas_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                csr_pready;

   weight_triggered_actuator_sequencer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_weight_grams (req_weight_grams),
      .req_stop_signal  (req_stop_signal),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_arm_pushed   (rsp_arm_pushed),
      .rsp_swing_high   (rsp_swing_high),
      .rsp_motor_run    (rsp_motor_run),
      .rsp_weight_event (rsp_weight_event),
      .rsp_stop_event   (rsp_stop_event),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   tick_in_type  pending_ticks[$];    // requests not yet handed to the driver
   tick_out_type predicted_levels[$]; // outcomes of accepted requests, oldest first
   int unsigned  mismatch_count = 0;
   int unsigned  req_gap = 0;
   int unsigned  rsp_stall = 0;
   logic         req_taken = 1'b0;    // request accepted at the last rising edge
   logic         calm = 1'b0;         // phase with no idling on either side
   logic         stop_level = 1'b0;   // random stop detector, changes in runs

   // local copy of the register file
   logic [14:0] cfg_threshold  = wtas_pkg::WEIGHT_THRESHOLD_RST;
   logic [14:0] cfg_hysteresis = wtas_pkg::WEIGHT_HYSTERESIS_RST;
   logic [15:0] cfg_hold       = wtas_pkg::PUSH_HOLD_TICKS_RST;
   logic [15:0] cfg_period     = wtas_pkg::SWING_PERIOD_TICKS_RST;
   logic [15:0] cfg_stop_len   = wtas_pkg::MOTOR_STOP_TICKS_RST;

   // local copy of the controller state, reset values
   logic                     trig_latched   = 1'b0;
   wtas_pkg::push_phase_type arm_phase      = wtas_pkg::PUSH_IDLE;
   logic [15:0]              arm_count      = '0;
   logic                     arm_out        = 1'b0;
   logic                     swing_on       = 1'b0;
   logic                     swing_out      = 1'b0;
   logic [15:0]              swing_count    = '0;
   logic                     halted         = 1'b0;
   logic                     wait_release   = 1'b0;
   logic [15:0]              halt_count     = '0;
   logic                     last_stop      = 1'b0;

   function automatic logic [15:0] bump16(input logic [15:0] value);
      return (value == 16'hFFFF) ? value : value + 16'd1;
   endfunction

   // ------------------------------------------------------------------------
   // Sequencer model: weight, stop signal, push arm, swing, in that order
   // ------------------------------------------------------------------------
   function automatic tick_out_type advance_tick(input logic signed [15:0] weight,
                                                 input logic stop);
      tick_out_type res;
      int           grams;
      int           thr;
      int           rearm;
      grams = weight;
      thr   = int'(cfg_threshold);
      rearm = thr - int'(cfg_hysteresis);   // may go negative, compared signed
      res   = '0;

      // weight trigger with hysteresis; a retrigger restarts the push
      if (grams >= thr && !trig_latched) begin
         trig_latched = 1'b1;
         swing_on     = 1'b1;
         arm_phase    = wtas_pkg::PUSH_START;
         res.weight_event = 1'b1;
      end
      if (grams < rearm)
         trig_latched = 1'b0;

      // stop: two high samples in a row halt the motor, then wait for low
      if (wait_release) begin
         if (!stop)
            wait_release = 1'b0;
      end else begin
         if (stop && last_stop && !halted) begin
            halted     = 1'b1;
            halt_count = '0;
            res.stop_event = 1'b1;
         end
         if (halted) begin
            halt_count = bump16(halt_count);
            if (halt_count >= cfg_stop_len) begin
               halted       = 1'b0;
               wait_release = stop;
            end
         end
      end
      last_stop = stop;

      case (arm_phase)
         wtas_pkg::PUSH_START: begin
            arm_out   = 1'b1;
            arm_phase = wtas_pkg::PUSH_HOLD;
            arm_count = '0;
         end
         wtas_pkg::PUSH_HOLD: begin
            arm_count = bump16(arm_count);
            if (arm_count >= cfg_hold)
               arm_phase = wtas_pkg::PUSH_PULL;
         end
         wtas_pkg::PUSH_PULL: begin
            arm_out   = 1'b0;
            arm_phase = wtas_pkg::PUSH_IDLE;
         end
         default: ;
      endcase

      // swing runs for good once the first trigger has fired
      if (swing_on) begin
         swing_count = bump16(swing_count);
         if (swing_count >= cfg_period) begin
            swing_count = '0;
            swing_out   = !swing_out;
         end
      end

      res.arm_pushed = arm_out;
      res.swing_high = swing_out;
      res.motor_run  = !halted;
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: changes at the falling edge, holds until accepted
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      tick_in_type next_tick;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap != 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            next_tick = pending_ticks.pop_front();
            req_weight_grams <= next_tick.weight;
            req_stop_signal  <= next_tick.stop;
            req_valid        <= 1'b1;
            req_gap          <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure; long stalls fill the two-deep pipe and stall requests
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            rsp_stall <= draw_gap();
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on request handshake, check on result handshake
   // ------------------------------------------------------------------------
   task automatic check_field(input string field, input logic want, input logic got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %b got %b", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      tick_out_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            predicted_levels.push_back(advance_tick(req_weight_grams, req_stop_signal));
         if (rsp_valid && rsp_ready) begin
            if (predicted_levels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no request outstanding", $realtime);
            end else begin
               want = predicted_levels.pop_front();
               check_field("arm_pushed",   want.arm_pushed,   rsp_arm_pushed);
               check_field("swing_high",   want.swing_high,   rsp_swing_high);
               check_field("motor_run",    want.motor_run,    rsp_motor_run);
               check_field("weight_event", want.weight_event, rsp_weight_event);
               check_field("stop_event",   want.stop_event,   rsp_stop_event);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Register writes: setup then access phase, done when pready is seen
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic [wtas_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [15:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(wtas_pkg::CSR_DATA_WIDTH-16){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         wtas_pkg::REG_WEIGHT_THRESHOLD:   cfg_threshold  = value[14:0];
         wtas_pkg::REG_WEIGHT_HYSTERESIS:  cfg_hysteresis = value[14:0];
         wtas_pkg::REG_PUSH_HOLD_TICKS:    cfg_hold       = value;
         wtas_pkg::REG_SWING_PERIOD_TICKS: cfg_period     = value;
         wtas_pkg::REG_MOTOR_STOP_TICKS:   cfg_stop_len   = value;
         default: ;
      endcase
   endtask

   // drained: nothing queued and nothing in flight, then an idle margin
   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_valid || predicted_levels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_tick(input logic signed [15:0] weight, input logic stop);
      tick_in_type t;
      t.weight = weight;
      t.stop   = stop;
      pending_ticks.push_back(t);
   endtask

   // One phase: program all registers, then random requests. Weights mostly
   // sit around the threshold/rearm band so the trigger toggles often; stop
   // comes in runs so debounce, halt and release all get exercised.
   task automatic run_phase(input int thr, input int hyst, input int hold,
                            input int period, input int stop_len, input int count);
      int r;
      int grams;
      write_reg(wtas_pkg::REG_WEIGHT_THRESHOLD,   16'(thr));
      write_reg(wtas_pkg::REG_WEIGHT_HYSTERESIS,  16'(hyst));
      write_reg(wtas_pkg::REG_PUSH_HOLD_TICKS,    16'(hold));
      write_reg(wtas_pkg::REG_SWING_PERIOD_TICKS, 16'(period));
      write_reg(wtas_pkg::REG_MOTOR_STOP_TICKS,   16'(stop_len));
      calm = ($urandom_range(0, 3) == 0);
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 4)
            grams = -32768;
         else if (r < 8)
            grams = 32767;
         else if (r < 20)
            grams = int'($urandom_range(0, 65535)) - 32768;
         else
            grams = thr - hyst - 3 + int'($urandom_range(0, hyst + 8));
         if (grams > 32767)
            grams = 32767;
         if (grams < -32768)
            grams = -32768;
         if ($urandom_range(0, 3) == 0)
            stop_level = !stop_level;
         queue_tick(grams[15:0], stop_level);
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int k;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: threshold 100, rearm below 90
      queue_tick(16'sh8000, 1'b0);
      queue_tick(16'sd32767, 1'b0);  // trigger fires, swing enabled
      queue_tick(16'sd0, 1'b0);      // rearm
      queue_tick(16'sd100, 1'b0);    // exactly at threshold
      queue_tick(16'sd99, 1'b0);
      queue_tick(16'sd90, 1'b0);     // on the rearm level, stays latched
      queue_tick(16'sd100, 1'b0);    // latched, no event
      queue_tick(16'sd89, 1'b0);     // just under rearm
      queue_tick(16'sd100, 1'b1);    // retrigger while the arm still holds
      queue_tick(16'sd101, 1'b1);    // second high sample, motor halts
      queue_tick(16'sd0, 1'b1);
      queue_tick(16'sd100, 1'b1);    // another retrigger mid-push
      queue_tick(-16'sd1, 1'b0);
      queue_tick(16'sd32767, 1'b1);
      queue_tick(16'sh8000, 1'b1);
      queue_tick(16'sd0, 1'b0);
      queue_tick(16'sd1, 1'b1);
      queue_tick(16'sd0, 1'b0);
      queue_tick(16'sd200, 1'b1);
      queue_tick(16'sd200, 1'b1);
      wait_idle();

      run_phase(100, 10, 3, 5, 4, 100);
      run_phase(0, 0, 1, 1, 1, 100);                    // low extremes
      run_phase(32767, 32767, 65535, 65535, 65535, 40); // high extremes
      run_phase(0, 32767, 0, 0, 0, 100);                // zero lengths, rearm far negative
      for (k = 0; k < 4; k++)
         run_phase($urandom_range(0, 32767),
                   (k == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 40),
                   $urandom_range(1, 12), $urandom_range(1, 12),
                   $urandom_range(1, 16), 100);

      if (mismatch_count == 0)
         $display("** weight_triggered_actuator_sequencer_unit: PASSED **");
      else
         $display("** weight_triggered_actuator_sequencer_unit: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("** weight_triggered_actuator_sequencer_unit: FAILED **");
      $finish;
   end

endmodule

/* weight_triggered_actuator_sequencer_unit.f */
+incdir+rtl
rtl/wtas_pkg.sv
rtl/weight_triggered_actuator_sequencer_unit.sv
bench/weight_triggered_actuator_sequencer_unit_tb.sv
